@@ rtl/lpte_pkg.sv @@
package lpte_pkg;

  // field widths
  localparam int PIX_W      = 15;
  localparam int POS_W      = 16;
  localparam int YAW_W      = 15;

  // fixed-point formats
  localparam int FRAC_BITS  = 20;
  localparam int COEF_W     = 28;
  localparam int COEF_FRAC  = 24;
  localparam int NUM_TERMS  = 15;

  // cordic
  localparam int CORDIC_ITERS = 16;
  localparam int ZW           = 20;
  localparam int CXW          = 28;

  localparam int IMAGE_SIZE_DEF = 2048;

  localparam logic signed [YAW_W-1:0] YAW_OFFSET_RST = 15'sd184;
  localparam logic signed [16:0]      PI_Q12         = 17'sd12868;
  localparam logic signed [16:0]      TWO_PI_Q12     = 17'sd25736;
  localparam logic signed [ZW-1:0]    HALF_PI_Q16    = 20'sd102944;

  localparam logic signed [COEF_W-1:0] COEF_X [NUM_TERMS] = '{
    28'sd73000200, -28'sd81591963, -28'sd1985199, 28'sd18360700, 28'sd8156457,
    28'sd2379799, -28'sd11242315, 28'sd5116162, -28'sd7318398, 28'sd3108424,
    -28'sd1287954, -28'sd1223041, -28'sd2202912, -28'sd1500723, -28'sd941007
  };

  localparam logic signed [COEF_W-1:0] COEF_Y [NUM_TERMS] = '{
    -28'sd5719893, 28'sd8767899, 28'sd82375980, -28'sd6545698, -28'sd8740066,
    -28'sd18339108, 28'sd1009383, 28'sd8558279, -28'sd5196915, 28'sd9298222,
    -28'sd482387, 28'sd851169, 28'sd2991651, 28'sd1686879, 28'sd1870571
  };

  localparam logic signed [ZW-1:0] ATAN_Q16 [CORDIC_ITERS] = '{
    20'sd51472, 20'sd30385, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
    20'sd8, 20'sd4, 20'sd2
  };

endpackage

@@ rtl/led_triangle_pose_estimator_core.sv @@
// channel  | handshake              | payload
// ---------+------------------------+----------------------------------------------
// input    | in_valid / in_stall    | led0_px led0_py led1_px led1_py led2_px led2_py
// output   | out_valid / out_stall  | pos_x pos_y yaw
// config   | cfg_wr_en              | cfg_wr_data (yaw_offset)
//
// 28 register stages, one triple per cycle unless out_stall holds the pipeline; the 16
// unrolled cordic stages and three monomial multiply stages set the depth
// rst is synchronous, clears all valid bits and loads yaw_offset with 0.045 rad
// each stage holds while the stage after it is full and stalled, so empty stages
// keep filling while a result waits on out_stall
// IMAGE_SIZE must be a power of two
module led_triangle_pose_estimator_core
  import lpte_pkg::*;
#(
  parameter int IMAGE_SIZE = IMAGE_SIZE_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [YAW_W-1:0]        cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [PIX_W-1:0]        led0_px,
  input  logic [PIX_W-1:0]        led0_py,
  input  logic [PIX_W-1:0]        led1_px,
  input  logic [PIX_W-1:0]        led1_py,
  input  logic [PIX_W-1:0]        led2_px,
  input  logic [PIX_W-1:0]        led2_py,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic signed [YAW_W-1:0] yaw
);

  // normalized coordinate is p * 2^16 / IMAGE_SIZE
  localparam int NORM_SHIFT = $clog2(IMAGE_SIZE);
  localparam int U_W  = PIX_W + 16 - NORM_SHIFT;
  // monomial width: fourth-order powers can grow past u itself
  localparam int MW   = (4 * U_W - 3 * FRAC_BITS > U_W) ? 4 * U_W - 3 * FRAC_BITS : U_W;
  localparam int TW   = COEF_W + MW + 1 - COEF_FRAC;
  localparam int SW   = TW + 4;
  localparam int DW   = POS_W + 1;
  localparam int NST  = 12 + CORDIC_ITERS;
  localparam int CB   = 11;  // first cordic iteration stage

  logic [NST-1:0] v;
  logic [NST-1:0] en;

  // bubble-collapsing advance: a stage loads when empty or when its successor moves
  always_comb begin
    en[NST-1] = !v[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // configuration register
  logic signed [YAW_W-1:0] yaw_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      yaw_offset <= YAW_OFFSET_RST;
    end else if (cfg_wr_en) begin
      yaw_offset <= cfg_wr_data;
    end
  end

  function automatic logic [MW-1:0] mulq(input logic [MW-1:0] a, input logic [MW-1:0] b);
    logic [2*MW-1:0] p;
    p = (2 * MW)'(a) * (2 * MW)'(b);
    return MW'(p >> FRAC_BITS);
  endfunction

  function automatic logic signed [TW-1:0] term(input logic signed [COEF_W-1:0] c,
                                                input logic [MW-1:0] m);
    logic signed [COEF_W+MW:0] p;
    p = c * $signed({1'b0, m});
    return TW'(p >>> COEF_FRAC);
  endfunction

  function automatic logic [MW-1:0] norm(input logic [PIX_W-1:0] p);
    logic [PIX_W+15:0] e;
    e = {p, 16'b0};
    return MW'(e >> NORM_SHIFT);
  endfunction

  // stage 0: normalize
  logic [MW-1:0] s0_x [3];
  logic [MW-1:0] s0_y [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_x[0] <= norm(led0_px);
      s0_y[0] <= norm(led0_py);
      s0_x[1] <= norm(led1_px);
      s0_y[1] <= norm(led1_py);
      s0_x[2] <= norm(led2_px);
      s0_y[2] <= norm(led2_py);
    end
  end

  // stages 1-3: monomials, index order x y x2 xy y2 x3 x2y xy2 y3 x4 x3y x2y2 xy3 y4
  logic [MW-1:0] s1_m [3][1:5];
  logic [MW-1:0] s2_m [3][1:9];
  logic [MW-1:0] s3_m [3][1:14];

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      if (en[1]) begin
        s1_m[l][1] <= s0_x[l];
        s1_m[l][2] <= s0_y[l];
        s1_m[l][3] <= mulq(s0_x[l], s0_x[l]);
        s1_m[l][4] <= mulq(s0_x[l], s0_y[l]);
        s1_m[l][5] <= mulq(s0_y[l], s0_y[l]);
      end
      if (en[2]) begin
        for (int k = 1; k <= 5; k++) begin
          s2_m[l][k] <= s1_m[l][k];
        end
        s2_m[l][6] <= mulq(s1_m[l][3], s1_m[l][1]);
        s2_m[l][7] <= mulq(s1_m[l][3], s1_m[l][2]);
        s2_m[l][8] <= mulq(s1_m[l][1], s1_m[l][5]);
        s2_m[l][9] <= mulq(s1_m[l][5], s1_m[l][2]);
      end
      if (en[3]) begin
        for (int k = 1; k <= 9; k++) begin
          s3_m[l][k] <= s2_m[l][k];
        end
        s3_m[l][10] <= mulq(s2_m[l][6], s2_m[l][1]);
        s3_m[l][11] <= mulq(s2_m[l][6], s2_m[l][2]);
        s3_m[l][12] <= mulq(s2_m[l][3], s2_m[l][5]);
        s3_m[l][13] <= mulq(s2_m[l][1], s2_m[l][9]);
        s3_m[l][14] <= mulq(s2_m[l][9], s2_m[l][2]);
      end
    end
  end

  // stage 4: coefficient products, constant term is coef / 16 floored
  logic signed [TW-1:0] s4_tx [3][NUM_TERMS];
  logic signed [TW-1:0] s4_ty [3][NUM_TERMS];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int l = 0; l < 3; l++) begin
        s4_tx[l][0] <= TW'(COEF_X[0] >>> (COEF_FRAC - FRAC_BITS));
        s4_ty[l][0] <= TW'(COEF_Y[0] >>> (COEF_FRAC - FRAC_BITS));
        for (int k = 1; k < NUM_TERMS; k++) begin
          s4_tx[l][k] <= term(COEF_X[k], s3_m[l][k]);
          s4_ty[l][k] <= term(COEF_Y[k], s3_m[l][k]);
        end
      end
    end
  end

  // stage 5: partial sums of up to four terms
  logic signed [SW-1:0] s5_px [3][4];
  logic signed [SW-1:0] s5_py [3][4];
  logic signed [SW-1:0] s5_px_next [3][4];
  logic signed [SW-1:0] s5_py_next [3][4];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      for (int g = 0; g < 4; g++) begin
        s5_px_next[l][g] = '0;
        s5_py_next[l][g] = '0;
        for (int j = 0; j < 4; j++) begin
          if (4 * g + j < NUM_TERMS) begin
            s5_px_next[l][g] = s5_px_next[l][g] + SW'(s4_tx[l][4*g+j]);
            s5_py_next[l][g] = s5_py_next[l][g] + SW'(s4_ty[l][4*g+j]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_px <= s5_px_next;
      s5_py <= s5_py_next;
    end
  end

  // stage 6: total, round to Q4.12, saturate
  function automatic logic signed [POS_W-1:0] round_sat(input logic signed [SW-1:0] a,
                                                        input logic signed [SW-1:0] b,
                                                        input logic signed [SW-1:0] c,
                                                        input logic signed [SW-1:0] d);
    logic signed [SW+1:0] s;
    logic signed [SW+1:0] r;
    s = (SW + 2)'(a) + (SW + 2)'(b) + (SW + 2)'(c) + (SW + 2)'(d) + (SW + 2)'(128);
    r = s >>> (FRAC_BITS - 12);
    if (r > (SW + 2)'(32767)) begin
      return 16'sh7FFF;
    end else if (r < -(SW + 2)'(32768)) begin
      return -16'sh8000;
    end
    return POS_W'(r);
  endfunction

  logic signed [POS_W-1:0] s6_fx [3];
  logic signed [POS_W-1:0] s6_fy [3];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int l = 0; l < 3; l++) begin
        s6_fx[l] <= round_sat(s5_px[l][0], s5_px[l][1], s5_px[l][2], s5_px[l][3]);
        s6_fy[l] <= round_sat(s5_py[l][0], s5_py[l][1], s5_py[l][2], s5_py[l][3]);
      end
    end
  end

  // stage 7: squared edge lengths, edge i runs from vertex i to vertex i+1
  logic [2*DW-1:0]         s7_d  [3];
  logic signed [POS_W-1:0] s7_fx [3];
  logic signed [POS_W-1:0] s7_fy [3];
  logic [2*DW-1:0]         s7_d_next [3];

  always_comb begin
    logic signed [DW-1:0]     dx;
    logic signed [DW-1:0]     dy;
    logic signed [2*DW:0]     sq;
    for (int i = 0; i < 3; i++) begin
      dx = DW'(s6_fx[(i+1)%3]) - DW'(s6_fx[i]);
      dy = DW'(s6_fy[(i+1)%3]) - DW'(s6_fy[i]);
      sq = dx * dx + dy * dy;
      s7_d_next[i] = (2 * DW)'(sq);
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_d  <= s7_d_next;
      s7_fx <= s6_fx;
      s7_fy <= s6_fy;
    end
  end

  // stage 8: longest edge (first maximum), origin opposite, adjacent edges
  logic [1:0] org, va, vb;

  always_comb begin
    logic [1:0]       bi;
    logic [2*DW-1:0]  best;
    if (s7_d[1] > s7_d[0]) begin
      bi   = 2'd1;
      best = s7_d[1];
    end else begin
      bi   = 2'd0;
      best = s7_d[0];
    end
    if (s7_d[2] > best) begin
      bi = 2'd2;
    end
    unique case (bi)
      2'd0:    begin org = 2'd2; va = 2'd0; vb = 2'd1; end
      2'd1:    begin org = 2'd0; va = 2'd1; vb = 2'd2; end
      default: begin org = 2'd1; va = 2'd2; vb = 2'd0; end
    endcase
  end

  logic signed [DW-1:0]    s8_dx1, s8_dy1, s8_dx2, s8_dy2;
  logic signed [POS_W-1:0] s8_ox, s8_oy;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_dx1 <= DW'(s7_fx[va]) - DW'(s7_fx[org]);
      s8_dy1 <= DW'(s7_fy[va]) - DW'(s7_fy[org]);
      s8_dx2 <= DW'(s7_fx[vb]) - DW'(s7_fx[org]);
      s8_dy2 <= DW'(s7_fy[vb]) - DW'(s7_fy[org]);
      s8_ox  <= s7_fx[org];
      s8_oy  <= s7_fy[org];
    end
  end

  // stage 9: cross product halves
  logic signed [2*DW-1:0]  s9_c1, s9_c2;
  logic signed [DW-1:0]    s9_dx1, s9_dy1, s9_dx2, s9_dy2;
  logic signed [POS_W-1:0] s9_ox, s9_oy;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_c1  <= s8_dx1 * s8_dy2;
      s9_c2  <= s8_dy1 * s8_dx2;
      s9_dx1 <= s8_dx1;
      s9_dy1 <= s8_dy1;
      s9_dx2 <= s8_dx2;
      s9_dy2 <= s8_dy2;
      s9_ox  <= s8_ox;
      s9_oy  <= s8_oy;
    end
  end

  // stage 10: pick edge, scale by 256, fold left half plane by a quarter turn
  logic signed [CXW-1:0]   c_x    [CORDIC_ITERS+1];
  logic signed [CXW-1:0]   c_y    [CORDIC_ITERS+1];
  logic signed [ZW-1:0]    c_z    [CORDIC_ITERS+1];
  logic                    c_zero [CORDIC_ITERS+1];
  logic signed [POS_W-1:0] c_px   [CORDIC_ITERS+1];
  logic signed [POS_W-1:0] c_py   [CORDIC_ITERS+1];

  logic signed [CXW-1:0] c_x_next [CORDIC_ITERS+1];
  logic signed [CXW-1:0] c_y_next [CORDIC_ITERS+1];
  logic signed [ZW-1:0]  c_z_next [CORDIC_ITERS+1];
  logic                  c_zero_next;

  always_comb begin
    logic signed [DW-1:0]  vx;
    logic signed [DW-1:0]  vy;
    logic signed [CXW-1:0] sx;
    logic signed [CXW-1:0] sy;
    if (s9_c1 > s9_c2) begin
      vx = s9_dx1;
      vy = s9_dy1;
    end else begin
      vx = s9_dx2;
      vy = s9_dy2;
    end
    c_zero_next = (vx == '0) && (vy == '0);
    sx = CXW'(vx) <<< 8;
    sy = CXW'(vy) <<< 8;
    if (sx < 0 && sy >= 0) begin
      c_x_next[0] = sy;
      c_y_next[0] = -sx;
      c_z_next[0] = HALF_PI_Q16;
    end else if (sx < 0) begin
      c_x_next[0] = -sy;
      c_y_next[0] = sx;
      c_z_next[0] = -HALF_PI_Q16;
    end else begin
      c_x_next[0] = sx;
      c_y_next[0] = sy;
      c_z_next[0] = '0;
    end
    // one vectoring iteration per stage
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (c_y[i] >= 0) begin
        c_x_next[i+1] = c_x[i] + (c_y[i] >>> i);
        c_y_next[i+1] = c_y[i] - (c_x[i] >>> i);
        c_z_next[i+1] = c_z[i] + ATAN_Q16[i];
      end else begin
        c_x_next[i+1] = c_x[i] - (c_y[i] >>> i);
        c_y_next[i+1] = c_y[i] + (c_x[i] >>> i);
        c_z_next[i+1] = c_z[i] - ATAN_Q16[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[CB-1]) begin
      c_x[0]    <= c_x_next[0];
      c_y[0]    <= c_y_next[0];
      c_z[0]    <= c_z_next[0];
      c_zero[0] <= c_zero_next;
      c_px[0]   <= s9_ox;
      c_py[0]   <= s9_oy;
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (en[CB+i]) begin
        c_x[i+1]    <= c_x_next[i+1];
        c_y[i+1]    <= c_y_next[i+1];
        c_z[i+1]    <= c_z_next[i+1];
        c_zero[i+1] <= c_zero[i];
        c_px[i+1]   <= c_px[i];
        c_py[i+1]   <= c_py[i];
      end
    end
  end

  // last stage: round to Q3.12, add offset, wrap into plus/minus pi
  logic signed [YAW_W-1:0] yaw_next;

  always_comb begin
    logic signed [ZW-1:0] ang;
    logic signed [ZW-1:0] rnd;
    logic signed [16:0]   sum;
    ang = c_zero[CORDIC_ITERS] ? '0 : c_z[CORDIC_ITERS];
    rnd = (ang + ZW'(8)) >>> 4;
    sum = 17'(rnd) + 17'(yaw_offset);
    if (sum > PI_Q12) begin
      sum = sum - TWO_PI_Q12;
    end else if (sum < -PI_Q12) begin
      sum = sum + TWO_PI_Q12;
    end
    yaw_next = YAW_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      pos_x <= c_px[CORDIC_ITERS];
      pos_y <= c_py[CORDIC_ITERS];
      yaw   <= yaw_next;
    end
  end

  // checks
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v[0])
    else $error("accepted transfer did not enter stage 0");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (&v) && out_stall |-> in_stall)
    else $error("full pipeline accepted a transfer under output stall");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (yaw <= 15'sd12868) && (yaw >= -15'sd12868))
    else $error("yaw outside plus/minus pi");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> v == '0)
    else $error("valid bits not cleared by reset");

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(yaw) && $stable(pos_x))
    else $error("stalled result changed");

endmodule
